// ===== rtl/lpe_pkg.sv =====
// lpe_pkg: shared constants, control word type, microcode ROM and reciprocal ROM
// for the Legendre polynomial evaluator. No dependencies.
package lpe_pkg;

   localparam int MAX_DEGREE = 32;
   localparam int FRAC_BITS  = 30;
   localparam int RECIP_BITS = 32;

   localparam int X_W    = 32;
   localparam int DEG_W  = 6;
   localparam int VAL_W  = 56;
   localparam int SUM_W  = VAL_W + 2;
   localparam int ACC_W  = 64;
   localparam int MAG_W  = 63;
   localparam int MB_W   = 32;
   localparam int PROD_W = MAG_W + MB_W;
   localparam int RND_W  = PROD_W + 1;
   localparam int PC_W   = 6;
   localparam int OP_W   = 4;
   localparam int FAM_W  = 2;

   localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_BITS;
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // micro-ops
   localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
   localparam logic [OP_W-1:0] OP_LDX  = 4'd1;  // load |cur|, |x|
   localparam logic [OP_W-1:0] OP_LDR  = 4'd2;  // load |acc|, reciprocal
   localparam logic [OP_W-1:0] OP_MUL0 = 4'd3;  // low partial product
   localparam logic [OP_W-1:0] OP_MUL1 = 4'd4;  // high partial product
   localparam logic [OP_W-1:0] OP_RNDF = 4'd5;  // round, drop FRAC_BITS
   localparam logic [OP_W-1:0] OP_RNDR = 4'd6;  // round, drop RECIP_BITS
   localparam logic [OP_W-1:0] OP_WRT  = 4'd7;  // t = sat(prod + addend)
   localparam logic [OP_W-1:0] OP_ACC1 = 4'd8;  // acc = (2k+1)*t
   localparam logic [OP_W-1:0] OP_ACC2 = 4'd9;  // acc -= k*prev
   localparam logic [OP_W-1:0] OP_WRR  = 4'd10; // prev = cur, cur = prod
   localparam logic [OP_W-1:0] OP_JGE  = 4'd11; // jump if k >= n
   localparam logic [OP_W-1:0] OP_INCJ = 4'd12; // k++, jump
   localparam logic [OP_W-1:0] OP_DONE = 4'd13;

   localparam logic [FAM_W-1:0] FAM_P = 2'd0;
   localparam logic [FAM_W-1:0] FAM_D = 2'd1;
   localparam logic [FAM_W-1:0] FAM_H = 2'd2;

   localparam logic [PC_W-1:0] PC_LOOP = 6'd0;
   localparam logic [PC_W-1:0] PC_DONE = 6'd38;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [FAM_W-1:0] fam;
      logic [PC_W-1:0]  tgt;
   } ctl_type;

   function automatic ctl_type cw(input logic [OP_W-1:0] op, input logic [FAM_W-1:0] fam,
                                  input logic [PC_W-1:0] tgt);
      ctl_type w;
      w.op  = op;
      w.fam = fam;
      w.tgt = tgt;
      return w;
   endfunction

   // one recurrence step per family, order H, D, P
   function automatic ctl_type ucode(input logic [PC_W-1:0] pc);
      ctl_type w;
      case (pc)
         6'd0:    w = cw(OP_JGE,  FAM_P, PC_DONE);
         6'd1:    w = cw(OP_LDX,  FAM_H, PC_LOOP);
         6'd2:    w = cw(OP_MUL0, FAM_H, PC_LOOP);
         6'd3:    w = cw(OP_MUL1, FAM_H, PC_LOOP);
         6'd4:    w = cw(OP_RNDF, FAM_H, PC_LOOP);
         6'd5:    w = cw(OP_WRT,  FAM_H, PC_LOOP);
         6'd6:    w = cw(OP_ACC1, FAM_H, PC_LOOP);
         6'd7:    w = cw(OP_ACC2, FAM_H, PC_LOOP);
         6'd8:    w = cw(OP_LDR,  FAM_H, PC_LOOP);
         6'd9:    w = cw(OP_MUL0, FAM_H, PC_LOOP);
         6'd10:   w = cw(OP_MUL1, FAM_H, PC_LOOP);
         6'd11:   w = cw(OP_RNDR, FAM_H, PC_LOOP);
         6'd12:   w = cw(OP_WRR,  FAM_H, PC_LOOP);
         6'd13:   w = cw(OP_LDX,  FAM_D, PC_LOOP);
         6'd14:   w = cw(OP_MUL0, FAM_D, PC_LOOP);
         6'd15:   w = cw(OP_MUL1, FAM_D, PC_LOOP);
         6'd16:   w = cw(OP_RNDF, FAM_D, PC_LOOP);
         6'd17:   w = cw(OP_WRT,  FAM_D, PC_LOOP);
         6'd18:   w = cw(OP_ACC1, FAM_D, PC_LOOP);
         6'd19:   w = cw(OP_ACC2, FAM_D, PC_LOOP);
         6'd20:   w = cw(OP_LDR,  FAM_D, PC_LOOP);
         6'd21:   w = cw(OP_MUL0, FAM_D, PC_LOOP);
         6'd22:   w = cw(OP_MUL1, FAM_D, PC_LOOP);
         6'd23:   w = cw(OP_RNDR, FAM_D, PC_LOOP);
         6'd24:   w = cw(OP_WRR,  FAM_D, PC_LOOP);
         6'd25:   w = cw(OP_LDX,  FAM_P, PC_LOOP);
         6'd26:   w = cw(OP_MUL0, FAM_P, PC_LOOP);
         6'd27:   w = cw(OP_MUL1, FAM_P, PC_LOOP);
         6'd28:   w = cw(OP_RNDF, FAM_P, PC_LOOP);
         6'd29:   w = cw(OP_WRT,  FAM_P, PC_LOOP);
         6'd30:   w = cw(OP_ACC1, FAM_P, PC_LOOP);
         6'd31:   w = cw(OP_ACC2, FAM_P, PC_LOOP);
         6'd32:   w = cw(OP_LDR,  FAM_P, PC_LOOP);
         6'd33:   w = cw(OP_MUL0, FAM_P, PC_LOOP);
         6'd34:   w = cw(OP_MUL1, FAM_P, PC_LOOP);
         6'd35:   w = cw(OP_RNDR, FAM_P, PC_LOOP);
         6'd36:   w = cw(OP_WRR,  FAM_P, PC_LOOP);
         6'd37:   w = cw(OP_INCJ, FAM_P, PC_LOOP);
         6'd38:   w = cw(OP_DONE, FAM_P, PC_LOOP);
         default: w = cw(OP_DONE, FAM_P, PC_LOOP);
      endcase
      return w;
   endfunction

   // round(2^32 / d)
   function automatic logic [MB_W-1:0] recip_lut(input logic [DEG_W-1:0] d);
      logic [MB_W-1:0] r;
      case (d)
         6'd2:    r = 32'd2147483648;
         6'd3:    r = 32'd1431655765;
         6'd4:    r = 32'd1073741824;
         6'd5:    r = 32'd858993459;
         6'd6:    r = 32'd715827883;
         6'd7:    r = 32'd613566757;
         6'd8:    r = 32'd536870912;
         6'd9:    r = 32'd477218588;
         6'd10:   r = 32'd429496730;
         6'd11:   r = 32'd390451572;
         6'd12:   r = 32'd357913941;
         6'd13:   r = 32'd330382100;
         6'd14:   r = 32'd306783378;
         6'd15:   r = 32'd286331153;
         6'd16:   r = 32'd268435456;
         6'd17:   r = 32'd252645135;
         6'd18:   r = 32'd238609294;
         6'd19:   r = 32'd226050910;
         6'd20:   r = 32'd214748365;
         6'd21:   r = 32'd204522252;
         6'd22:   r = 32'd195225786;
         6'd23:   r = 32'd186737709;
         6'd24:   r = 32'd178956971;
         6'd25:   r = 32'd171798692;
         6'd26:   r = 32'd165191050;
         6'd27:   r = 32'd159072863;
         6'd28:   r = 32'd153391689;
         6'd29:   r = 32'd148102321;
         6'd30:   r = 32'd143165577;
         6'd31:   r = 32'd138547332;
         6'd32:   r = 32'd134217728;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/lpe_mul.sv =====
// lpe_mul: shared sign-magnitude multiplier, 63x32-bit product from two partial products,
// round-to-nearest shift and saturation. Depends on lpe_pkg.
module lpe_mul (
   input  logic                                  clock,
   input  logic [lpe_pkg::OP_W-1:0]              op,
   input  logic signed [lpe_pkg::VAL_W-1:0]      src_val,
   input  logic signed [lpe_pkg::X_W-1:0]        x_val,
   input  logic signed [lpe_pkg::ACC_W-1:0]      acc_val,
   input  logic [lpe_pkg::MB_W-1:0]              recip_val,
   output logic signed [lpe_pkg::VAL_W-1:0]      result
);

   logic [lpe_pkg::MAG_W-1:0]  mag_a_ff, mag_a_in;
   logic [lpe_pkg::MB_W-1:0]   mag_b_ff, mag_b_in;
   logic                       neg_ff, neg_in;
   logic [lpe_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [lpe_pkg::VAL_W-1:0]  q_ff, q_in;

   logic [lpe_pkg::VAL_W-1:0]  src_abs;
   logic [lpe_pkg::X_W-1:0]    x_abs;
   logic [lpe_pkg::ACC_W-1:0]  acc_abs;
   logic [2*lpe_pkg::MB_W-1:0] lo_pp;
   logic [lpe_pkg::MAG_W-1:0]  hi_pp;
   logic [lpe_pkg::RND_W-1:0]  prod_ext, shifted_f, shifted_r, shifted;
   logic [lpe_pkg::VAL_W-1:0]  lim;

   assign src_abs  = src_val[lpe_pkg::VAL_W-1] ? (~src_val + 1'b1) : src_val;
   assign x_abs    = x_val[lpe_pkg::X_W-1] ? (~x_val + 1'b1) : x_val;
   assign acc_abs  = acc_val[lpe_pkg::ACC_W-1] ? (~acc_val + 1'b1) : acc_val;

   assign lo_pp    = mag_a_ff[lpe_pkg::MB_W-1:0] * mag_b_ff;
   assign hi_pp    = mag_a_ff[lpe_pkg::MAG_W-1:lpe_pkg::MB_W] * mag_b_ff;

   assign prod_ext  = {1'b0, prod_ff};
   assign shifted_f = (prod_ext + (lpe_pkg::RND_W'(1) << (lpe_pkg::FRAC_BITS - 1)))
                      >> lpe_pkg::FRAC_BITS;
   assign shifted_r = (prod_ext + (lpe_pkg::RND_W'(1) << (lpe_pkg::RECIP_BITS - 1)))
                      >> lpe_pkg::RECIP_BITS;
   assign shifted   = (op == lpe_pkg::OP_RNDR) ? shifted_r : shifted_f;
   assign lim       = neg_ff ? lpe_pkg::VAL_MIN : lpe_pkg::VAL_MAX;

   assign result = neg_ff ? $signed(~q_ff + 1'b1) : $signed(q_ff);

   always_comb begin
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      case (op)
         lpe_pkg::OP_LDX: begin
            mag_a_in = lpe_pkg::MAG_W'(src_abs);
            mag_b_in = x_abs;
            neg_in   = src_val[lpe_pkg::VAL_W-1] ^ x_val[lpe_pkg::X_W-1];
         end
         lpe_pkg::OP_LDR: begin
            mag_a_in = acc_abs[lpe_pkg::MAG_W-1:0];
            mag_b_in = recip_val;
            neg_in   = acc_val[lpe_pkg::ACC_W-1];
         end
         lpe_pkg::OP_MUL0: begin
            prod_in = lpe_pkg::PROD_W'(lo_pp);
         end
         lpe_pkg::OP_MUL1: begin
            prod_in = prod_ff + {hi_pp, {lpe_pkg::MB_W{1'b0}}};
         end
         lpe_pkg::OP_RNDF, lpe_pkg::OP_RNDR: begin
            q_in = (shifted > lpe_pkg::RND_W'(lim)) ? lim : shifted[lpe_pkg::VAL_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
   end

endmodule

// ===== rtl/lpe_seq.sv =====
// lpe_seq: microcode sequencer, step counter, conditional jumps and busy flag.
// Depends on lpe_pkg (control word type and microcode ROM).
module lpe_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic                loop_exit,
   output lpe_pkg::ctl_type    ctl,
   output logic                busy
);

   logic [lpe_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                     busy_ff, busy_in;

   assign busy = busy_ff;
   assign ctl  = busy_ff ? lpe_pkg::ucode(pc_ff)
                         : lpe_pkg::cw(lpe_pkg::OP_NOP, lpe_pkg::FAM_P, lpe_pkg::PC_LOOP);

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (go) begin
         pc_in   = lpe_pkg::PC_LOOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (ctl.op)
            lpe_pkg::OP_JGE:  pc_in = loop_exit ? ctl.tgt : pc_ff + 1'b1;
            lpe_pkg::OP_INCJ: pc_in = ctl.tgt;
            lpe_pkg::OP_DONE: busy_in = 1'b0;
            default:          pc_in = pc_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= lpe_pkg::PC_LOOP;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/legendre_poly_eval.sv =====
// legendre_poly_eval: P_n(x), P'_n(x), P''_n(x) by three-term recurrence.
// From accept to rsp_strobe the sequencer runs the recurrence loop n-1 times, with n
// clamped to 32 (degree 0 or 1 skips the loop); one transaction at a time.
// Each recurrence step is 38 microcode steps on the shared lpe_mul multiplier.
// Synchronous reset clears the sequencer and the strobe; results cannot be stalled.
// Depends on lpe_pkg, lpe_seq, lpe_mul.
module legendre_poly_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [lpe_pkg::X_W-1:0]      req_x,
   input  logic [lpe_pkg::DEG_W-1:0]           req_degree,
   output logic                                rsp_strobe,
   output logic signed [lpe_pkg::VAL_W-1:0]    rsp_value,
   output logic signed [lpe_pkg::VAL_W-1:0]    rsp_slope,
   output logic signed [lpe_pkg::VAL_W-1:0]    rsp_curvature
);

   lpe_pkg::ctl_type ctl;
   logic             go;
   logic             loop_exit;

   logic signed [lpe_pkg::X_W-1:0]   x_ff, x_in;
   logic [lpe_pkg::DEG_W-1:0]        n_ff, n_in, deg_clamp;
   logic [lpe_pkg::DEG_W-1:0]        k_ff, k_in;
   logic signed [lpe_pkg::VAL_W-1:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [lpe_pkg::VAL_W-1:0] d0_ff, d0_in, d1_ff, d1_in;
   logic signed [lpe_pkg::VAL_W-1:0] h0_ff, h0_in, h1_ff, h1_in;
   logic signed [lpe_pkg::VAL_W-1:0] t_ff, t_in;
   logic signed [lpe_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                             rsp_strobe_ff;

   logic signed [lpe_pkg::VAL_W-1:0] cur_val, prev_val, mul_val;
   logic signed [lpe_pkg::SUM_W-1:0] addend, wsum;
   logic [lpe_pkg::DEG_W:0]          coef;
   logic signed [lpe_pkg::ACC_W-1:0] m1, m2;
   logic [lpe_pkg::MB_W-1:0]         recip;

   assign go        = start & ~busy;
   assign loop_exit = (k_ff >= n_ff);
   assign deg_clamp = (req_degree > lpe_pkg::DEG_W'(lpe_pkg::MAX_DEGREE))
                      ? lpe_pkg::DEG_W'(lpe_pkg::MAX_DEGREE) : req_degree;
   assign coef      = {k_ff, 1'b1};
   assign recip     = lpe_pkg::recip_lut(k_ff + 1'b1);

   lpe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .loop_exit (loop_exit),
      .ctl       (ctl),
      .busy      (busy)
   );

   lpe_mul u_mul (
      .clock     (clock),
      .op        (ctl.op),
      .src_val   (cur_val),
      .x_val     (x_ff),
      .acc_val   (acc_ff),
      .recip_val (recip),
      .result    (mul_val)
   );

   always_comb begin
      case (ctl.fam)
         lpe_pkg::FAM_D: begin
            cur_val  = d1_ff;
            prev_val = d0_ff;
            addend   = lpe_pkg::SUM_W'(p1_ff);
         end
         lpe_pkg::FAM_H: begin
            cur_val  = h1_ff;
            prev_val = h0_ff;
            addend   = {d1_ff[lpe_pkg::VAL_W-1], d1_ff, 1'b0};
         end
         default: begin
            cur_val  = p1_ff;
            prev_val = p0_ff;
            addend   = '0;
         end
      endcase
   end

   assign wsum = lpe_pkg::SUM_W'(mul_val) + addend;
   assign m1   = lpe_pkg::ACC_W'(t_ff) * lpe_pkg::ACC_W'($signed({1'b0, coef}));
   assign m2   = lpe_pkg::ACC_W'(prev_val) * lpe_pkg::ACC_W'($signed({1'b0, k_ff}));

   always_comb begin
      x_in   = x_ff;
      n_in   = n_ff;
      k_in   = k_ff;
      p0_in  = p0_ff;
      p1_in  = p1_ff;
      d0_in  = d0_ff;
      d1_in  = d1_ff;
      h0_in  = h0_ff;
      h1_in  = h1_ff;
      t_in   = t_ff;
      acc_in = acc_ff;
      if (go) begin
         x_in  = req_x;
         n_in  = deg_clamp;
         k_in  = lpe_pkg::DEG_W'(1);
         p0_in = lpe_pkg::VAL_ONE;
         d0_in = '0;
         h0_in = '0;
         h1_in = '0;
         if (deg_clamp == '0) begin
            p1_in = lpe_pkg::VAL_ONE;
            d1_in = '0;
         end else begin
            p1_in = lpe_pkg::VAL_W'(req_x);
            d1_in = lpe_pkg::VAL_ONE;
         end
      end else begin
         case (ctl.op)
            lpe_pkg::OP_WRT: begin
               if (wsum > lpe_pkg::SUM_W'(lpe_pkg::VAL_MAX))
                  t_in = lpe_pkg::VAL_MAX;
               else if (wsum < lpe_pkg::SUM_W'(lpe_pkg::VAL_MIN))
                  t_in = lpe_pkg::VAL_MIN;
               else
                  t_in = wsum[lpe_pkg::VAL_W-1:0];
            end
            lpe_pkg::OP_ACC1: acc_in = m1;
            lpe_pkg::OP_ACC2: acc_in = acc_ff - m2;
            lpe_pkg::OP_WRR: begin
               case (ctl.fam)
                  lpe_pkg::FAM_D: begin
                     d0_in = d1_ff;
                     d1_in = mul_val;
                  end
                  lpe_pkg::FAM_H: begin
                     h0_in = h1_ff;
                     h1_in = mul_val;
                  end
                  default: begin
                     p0_in = p1_ff;
                     p1_in = mul_val;
                  end
               endcase
            end
            lpe_pkg::OP_INCJ: k_in = k_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      d0_ff  <= d0_in;
      d1_ff  <= d1_in;
      h0_ff  <= h0_in;
      h1_ff  <= h1_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (ctl.op == lpe_pkg::OP_DONE);
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = p1_ff;
   assign rsp_slope     = d1_ff;
   assign rsp_curvature = h1_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for legendre_poly_eval (P_n, P'_n, P''_n by recurrence).
// Directed table, then random transactions scored by a fixed-point predictor.
// Depends on lpe_pkg and legendre_poly_eval.
module tb_top;

   typedef struct packed {
      logic signed [lpe_pkg::VAL_W-1:0] value;
      logic signed [lpe_pkg::VAL_W-1:0] slope;
      logic signed [lpe_pkg::VAL_W-1:0] curvature;
   } poly_type;

   typedef struct packed {
      logic [lpe_pkg::X_W-1:0]   x;
      logic [lpe_pkg::DEG_W-1:0] degree;
      logic                      typed;
      poly_type                  poly;
   } stim_type;

   localparam int RAND_PER_PHASE = 567;
   localparam int SETTLE_CYCLES  = 1200;

   localparam logic [lpe_pkg::VAL_W-1:0] ONE  = lpe_pkg::VAL_ONE;
   localparam logic [lpe_pkg::VAL_W-1:0] MONE = 56'hFFFFFFC0000000;

   // x, degree, typed, {value, slope, curvature}
   localparam stim_type DIRECTED [0:24] = '{
      '{32'h00000000, 6'd0,  1'b1, '{ONE, 56'h0, 56'h0}},
      '{32'h40000000, 6'd0,  1'b1, '{ONE, 56'h0, 56'h0}},
      '{32'h80000000, 6'd0,  1'b1, '{ONE, 56'h0, 56'h0}},
      '{32'h00000000, 6'd1,  1'b1, '{56'h0, ONE, 56'h0}},
      '{32'h40000000, 6'd1,  1'b1, '{ONE, ONE, 56'h0}},
      '{32'hC0000000, 6'd1,  1'b1, '{MONE, ONE, 56'h0}},
      '{32'h7FFFFFFF, 6'd1,  1'b1, '{56'h7FFFFFFF, ONE, 56'h0}},
      '{32'h80000000, 6'd1,  1'b1, '{56'hFFFFFF80000000, ONE, 56'h0}},
      '{32'h00000000, 6'd2,  1'b1, '{56'hFFFFFFE0000000, 56'h0, 56'hC0000000}},
      '{32'h40000000, 6'd2,  1'b0, '0},
      '{32'hC0000000, 6'd2,  1'b0, '0},
      '{32'h20000000, 6'd3,  1'b0, '0},
      '{32'hE0000000, 6'd4,  1'b0, '0},
      '{32'h00000001, 6'd7,  1'b0, '0},
      '{32'hFFFFFFFF, 6'd8,  1'b0, '0},
      '{32'h2AAAAAAB, 6'd20, 1'b0, '0},
      '{32'h3FFFFFFF, 6'd31, 1'b0, '0},
      '{32'h40000000, 6'd32, 1'b0, '0},
      '{32'hC0000000, 6'd32, 1'b0, '0},
      '{32'h00000000, 6'd32, 1'b0, '0},
      '{32'h40000000, 6'd33, 1'b0, '0},
      '{32'hC0000000, 6'd63, 1'b0, '0},
      '{32'h7FFFFFFF, 6'd63, 1'b0, '0},
      '{32'h80000000, 6'd40, 1'b0, '0},
      '{32'h7FFFFFFF, 6'd10, 1'b0, '0}
   };

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic signed [lpe_pkg::X_W-1:0]   req_x;
   logic [lpe_pkg::DEG_W-1:0]        req_degree;
   logic                             rsp_strobe;
   logic signed [lpe_pkg::VAL_W-1:0] rsp_value;
   logic signed [lpe_pkg::VAL_W-1:0] rsp_slope;
   logic signed [lpe_pkg::VAL_W-1:0] rsp_curvature;

   poly_type expected_polys[$];
   int       errors = 0;
   int       idle_pct = 34;

   legendre_poly_eval uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x         (req_x),
      .req_degree    (req_degree),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value),
      .rsp_slope     (rsp_slope),
      .rsp_curvature (rsp_curvature)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sat56(input longint v);
      if (v > longint'(lpe_pkg::VAL_MAX)) return longint'(lpe_pkg::VAL_MAX);
      if (v < longint'(lpe_pkg::VAL_MIN)) return longint'(lpe_pkg::VAL_MIN);
      return v;
   endfunction

   // a*b, rounded half away from zero, shifted right by s, saturated
   function automatic longint mul_rnd(input longint a, input longint b, input int s);
      logic signed [127:0] sa, sb;
      logic [127:0]        mag, lim;
      logic                neg;
      sa = a;
      sb = b;
      neg = (a < 0) != (b < 0);
      if (sa < 0) sa = -sa;
      if (sb < 0) sb = -sb;
      mag = (sa * sb + (128'd1 << (s - 1))) >> s;
      lim = neg ? (128'd1 << (lpe_pkg::VAL_W - 1)) : (128'd1 << (lpe_pkg::VAL_W - 1)) - 128'd1;
      if (mag > lim) mag = lim;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint recip_of(input int d);
      return ((longint'(1) << lpe_pkg::RECIP_BITS) + longint'(d / 2)) / longint'(d);
   endfunction

   function automatic longint recur(input longint t, input longint prev, input int k);
      return mul_rnd(longint'(2 * k + 1) * t - longint'(k) * prev, recip_of(k + 1),
                     lpe_pkg::RECIP_BITS);
   endfunction

   function automatic poly_type legendre_predict(input logic [lpe_pkg::X_W-1:0] x,
                                                 input logic [lpe_pkg::DEG_W-1:0] deg);
      longint   xv, p0, p1, d0, d1, h0, h1, tp, td, th, np, nd, nh;
      int       n, k;
      poly_type r;
      xv = longint'($signed(x));
      n  = (deg > lpe_pkg::MAX_DEGREE) ? lpe_pkg::MAX_DEGREE : int'(deg);
      p0 = longint'(1) << lpe_pkg::FRAC_BITS;
      p1 = sat56(xv);
      d0 = 0;
      d1 = p0;
      h0 = 0;
      h1 = 0;
      if (n == 0) begin
         p1 = p0;
         d1 = 0;
      end
      for (k = 1; k < n; k++) begin
         tp = mul_rnd(xv, p1, lpe_pkg::FRAC_BITS);
         td = sat56(mul_rnd(xv, d1, lpe_pkg::FRAC_BITS) + p1);
         th = sat56(mul_rnd(xv, h1, lpe_pkg::FRAC_BITS) + 2 * d1);
         np = recur(tp, p0, k);
         nd = recur(td, d0, k);
         nh = recur(th, h0, k);
         p0 = p1;
         p1 = np;
         d0 = d1;
         d1 = nd;
         h0 = h1;
         h1 = nh;
      end
      r.value     = p1[lpe_pkg::VAL_W-1:0];
      r.slope     = d1[lpe_pkg::VAL_W-1:0];
      r.curvature = h1[lpe_pkg::VAL_W-1:0];
      return r;
   endfunction

   function automatic logic [lpe_pkg::X_W-1:0] pick_point();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(32'h80000000) - 32'h40000000;
      if (roll < 80) begin
         case ($urandom_range(4))
            0:       return 32'h40000000;
            1:       return 32'hC0000000;
            2:       return 32'h00000000;
            3:       return 32'h00000001;
            default: return 32'hFFFFFFFF;
         endcase
      end
      return $urandom();
   endfunction

   // mostly low degrees to keep the run short
   function automatic logic [lpe_pkg::DEG_W-1:0] pick_degree();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return lpe_pkg::DEG_W'($urandom_range(7));
      if (roll < 88) return lpe_pkg::DEG_W'($urandom_range(31, 8));
      return lpe_pkg::DEG_W'($urandom_range(63, 32));
   endfunction

   // call and return on a rising edge
   task automatic send(input logic [lpe_pkg::X_W-1:0] x, input logic [lpe_pkg::DEG_W-1:0] deg,
                       input poly_type expected);
      logic done;
      done = 1'b0;
      while (!done) begin
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            start      <= 1'b1;
            req_x      <= x;
            req_degree <= deg;
         end
         @(negedge clock);
         if (start && !busy) begin
            expected_polys.push_back(expected);
            done = 1'b1;
         end
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_polys.size() != 0) @(posedge clock);
   endtask

   task automatic flag(input string field, input logic [lpe_pkg::VAL_W-1:0] want,
                       input logic [lpe_pkg::VAL_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
   endtask

   always @(negedge clock) begin
      poly_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_polys.size() == 0) begin
            errors++;
            $display("%0t: result with no transaction pending", $time);
         end else begin
            want = expected_polys.pop_front();
            if (rsp_value !== want.value) flag("value", want.value, rsp_value);
            if (rsp_slope !== want.slope) flag("slope", want.slope, rsp_slope);
            if (rsp_curvature !== want.curvature)
               flag("curvature", want.curvature, rsp_curvature);
         end
      end
   end

   initial begin
      logic [lpe_pkg::X_W-1:0]   x;
      logic [lpe_pkg::DEG_W-1:0] deg;
      int                        phase, i;
      reset      = 1'b1;
      start      = 1'b0;
      req_x      = '0;
      req_degree = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         send(DIRECTED[r].x, DIRECTED[r].degree,
              DIRECTED[r].typed ? DIRECTED[r].poly
                                : legendre_predict(DIRECTED[r].x, DIRECTED[r].degree));
      end

      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 34 : (phase == 1) ? 84 : 0;
         if (phase == 1) drain();
         for (i = 0; i < RAND_PER_PHASE; i++) begin
            x   = pick_point();
            deg = pick_degree();
            send(x, deg, legendre_predict(x, deg));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_polys.size() == 0)
         $display("** legendre_poly_eval: PASSED **");
      else
         $display("** legendre_poly_eval: FAILED **");
      $finish;
   end

   initial begin
      #100000000;
      $display("timeout");
      $display("** legendre_poly_eval: FAILED **");
      $finish;
   end

endmodule
